FILE: rtl/run_length_byte_compressor_core_macros.svh
// Assertion macros for the run-length byte compressor core.
`ifndef RUN_LENGTH_BYTE_COMPRESSOR_CORE_MACROS_SVH
`define RUN_LENGTH_BYTE_COMPRESSOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RLBC_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rlbc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RLBC_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rlbc assertion failed");

`endif

FILE: rtl/rlbc_pkg.sv
// Types and constants of the run-length byte compressor.
package rlbc_pkg;

    localparam int MAX_LITERAL = 32;
    localparam int CNT_W       = $clog2(MAX_LITERAL + 1);
    localparam int ADDR_W      = (MAX_LITERAL > 1) ? $clog2(MAX_LITERAL) : 1;

    localparam logic [CNT_W-1:0] MAX_CNT      = CNT_W'(MAX_LITERAL);
    localparam logic [7:0]       RUN_MAX      = 8'd129;
    localparam logic [7:0]       RUN_HDR_BIAS = 8'd126;
    localparam logic [7:0]       RUN_START    = 8'd2;

    typedef enum logic [1:0] {
        PH_EMPTY  = 2'd0,
        PH_SINGLE = 2'd1,
        PH_RUN    = 2'd2
    } phase_t;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_LIT_HDR  = 6'b000010,
        ST_LIT_DATA = 6'b000100,
        ST_LIT_TAIL = 6'b001000,
        ST_RUN_HDR  = 6'b010000,
        ST_RUN_BYTE = 6'b100000
    } seq_state_t;

endpackage

FILE: rtl/run_length_byte_compressor_core.sv
// Run-length byte compressor core: PackBits-style coder around a literal store.
//
// Raw bytes come in on the s_axis side and leave as a PackBits-style code on
// the m_axis side. A run of L equal bytes (2..129) is coded as the header
// L+126 followed by the byte; a group of n bytes that are not part of a run
// (1..MAX_LITERAL) is coded as the header n-1 followed by the n bytes. A
// repeat flushes the pending literal group before the run starts, runs longer
// than 129 are split, and literal groups are cut at MAX_LITERAL. Zero bytes
// are plain data. s_axis_tlast closes the stream: everything pending is coded,
// m_axis_tlast marks the final coded byte, and the coder returns to its reset
// state. Timing: the intake of a request presents no coded byte; a request
// that releases k coded bytes (up to MAX_LITERAL+3) then has them handed out
// by the sequencer one coded byte per cycle while m_axis is not stalled,
// reading the literal store through its single registered read port;
// s_axis_tready stays low until the last one has moved on. Pending literals
// live in a synchronous MAX_LITERAL x 8 memory; it needs no clearing, only
// entries below the fill count are ever read.
`include "run_length_byte_compressor_core_macros.svh"

module run_length_byte_compressor_core
(
    input  logic       clk,
    input  logic       rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_in
    input  logic       s_axis_tlast,   // last_in
    // coded stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] byte_out
    output logic       m_axis_tlast    // last_out
);

    localparam int CW = rlbc_pkg::CNT_W;
    localparam int AW = rlbc_pkg::ADDR_W;

    // ------------------------------------------------------------------
    // Coder state
    // ------------------------------------------------------------------
    rlbc_pkg::phase_t     phase_reg,  phase_next;
    logic [7:0]           held_reg,   held_next;
    logic [7:0]           rlen_reg,   rlen_next;    // run length, 0..129
    logic [CW-1:0]        count_reg,  count_next;   // pending literals

    // Sequencer: pending work of the request being coded
    rlbc_pkg::seq_state_t state_reg,  state_next;
    logic                 run_pend_reg, run_pend_next;
    logic [7:0]           run_len_reg,  run_len_next;   // run to emit
    logic [7:0]           run_byte_reg, run_byte_next;
    logic                 f3_pend_reg,  f3_pend_next;   // closing group pending
    logic [CW-1:0]        f3_n_reg,     f3_n_next;
    logic [7:0]           tail_reg,     tail_next;      // closing group's last byte
    logic [CW-1:0]        grp_n_reg,    grp_n_next;     // stored bytes of group
    logic                 in_f3_reg,    in_f3_next;     // group carries tail byte
    logic [CW-1:0]        idx_reg,      idx_next;
    logic                 last_reg,     last_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           out_byte_reg,  out_byte_next;
    logic                 out_last_reg,  out_last_next;

    // Literal store
    logic [7:0]           lit_mem [rlbc_pkg::MAX_LITERAL];
    logic [7:0]           mem_rdata_reg;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [7:0]           wr_data;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;

    logic                 in_acc;
    logic                 out_free;
    logic                 emit_valid;
    logic [7:0]           emit_byte;
    logic                 emit_last;
    logic                 advance;
    logic                 chain;
    logic                 eq;
    logic                 full;
    logic [CW-1:0]        cnt_inc;
    logic [CW-1:0]        idx_inc;

    assign s_axis_tready = (state_reg == rlbc_pkg::ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    assign eq      = (s_axis_tdata == held_reg);
    assign cnt_inc = count_reg + CW'(1);
    assign full    = (cnt_inc == rlbc_pkg::MAX_CNT);
    assign idx_inc = idx_reg + CW'(1);

    // ------------------------------------------------------------------
    // Coded byte presented by the current sequencer state
    // ------------------------------------------------------------------
    always_comb
    begin
        emit_valid = 1'b1;
        emit_byte  = 8'd0;
        emit_last  = 1'b0;
        unique case (state_reg)
            rlbc_pkg::ST_LIT_HDR:
            begin
                emit_byte = 8'(grp_n_reg) + 8'(in_f3_reg) - 8'd1;
            end
            rlbc_pkg::ST_LIT_DATA:
            begin
                emit_byte = mem_rdata_reg;
            end
            rlbc_pkg::ST_LIT_TAIL:
            begin
                // tail group only closes a stream
                emit_byte = tail_reg;
                emit_last = 1'b1;
            end
            rlbc_pkg::ST_RUN_HDR:
            begin
                emit_byte = run_len_reg + rlbc_pkg::RUN_HDR_BIAS;
            end
            rlbc_pkg::ST_RUN_BYTE:
            begin
                emit_byte = run_byte_reg;
                emit_last = last_reg && !f3_pend_reg;
            end
            default:
            begin
                emit_valid = 1'b0;
            end
        endcase
    end

    assign advance = emit_valid && out_free;

    // ------------------------------------------------------------------
    // Request intake and sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next    = phase_reg;
        held_next     = held_reg;
        rlen_next     = rlen_reg;
        count_next    = count_reg;
        state_next    = state_reg;
        run_pend_next = run_pend_reg;
        run_len_next  = run_len_reg;
        run_byte_next = run_byte_reg;
        f3_pend_next  = f3_pend_reg;
        f3_n_next     = f3_n_reg;
        tail_next     = tail_reg;
        grp_n_next    = grp_n_reg;
        in_f3_next    = in_f3_reg;
        idx_next      = idx_reg;
        last_next     = last_reg;
        wr_en         = 1'b0;
        wr_addr       = count_reg[AW-1:0];
        wr_data       = held_reg;
        rd_en         = 1'b0;
        rd_addr       = idx_inc[AW-1:0];
        chain         = 1'b0;

        if (in_acc)
        begin
            logic          f1;
            logic [CW-1:0] f1_n;
            logic          run;
            logic          f3;
            f1   = 1'b0;
            f1_n = count_reg;
            run  = 1'b0;
            f3   = 1'b0;

            last_next = s_axis_tlast;
            tail_next = s_axis_tdata;
            f3_n_next = count_reg;

            unique case (phase_reg)
                rlbc_pkg::PH_SINGLE:
                begin
                    if (eq)
                    begin
                        // repeat: flush pending literals, run of two starts
                        f1            = (count_reg != '0);
                        count_next    = '0;
                        rlen_next     = rlbc_pkg::RUN_START;
                        phase_next    = rlbc_pkg::PH_RUN;
                        run           = s_axis_tlast;
                        run_len_next  = rlbc_pkg::RUN_START;
                        run_byte_next = held_reg;
                    end
                    else
                    begin
                        // held byte becomes a literal
                        wr_en      = 1'b1;
                        f1         = full;
                        f1_n       = rlbc_pkg::MAX_CNT;
                        count_next = full ? '0 : cnt_inc;
                        f3_n_next  = full ? '0 : cnt_inc;
                        held_next  = s_axis_tdata;
                        rlen_next  = 8'd1;
                        f3         = s_axis_tlast;
                    end
                end
                rlbc_pkg::PH_RUN:
                begin
                    run_byte_next = held_reg;
                    if (eq && (rlen_reg < rlbc_pkg::RUN_MAX))
                    begin
                        rlen_next    = rlen_reg + 8'd1;
                        run          = s_axis_tlast;
                        run_len_next = rlen_reg + 8'd1;
                    end
                    else
                    begin
                        // run ends (or is split at 129)
                        run          = 1'b1;
                        run_len_next = rlen_reg;
                        held_next    = s_axis_tdata;
                        rlen_next    = 8'd1;
                        phase_next   = rlbc_pkg::PH_SINGLE;
                        f3           = s_axis_tlast;
                    end
                end
                default:
                begin
                    held_next  = s_axis_tdata;
                    rlen_next  = 8'd1;
                    phase_next = rlbc_pkg::PH_SINGLE;
                    f3         = s_axis_tlast;
                end
            endcase

            if (s_axis_tlast)
            begin
                phase_next = rlbc_pkg::PH_EMPTY;
                held_next  = 8'd0;
                rlen_next  = 8'd0;
                count_next = '0;
            end

            run_pend_next = 1'b0;
            f3_pend_next  = 1'b0;
            if (f1)
            begin
                state_next    = rlbc_pkg::ST_LIT_HDR;
                grp_n_next    = f1_n;
                in_f3_next    = 1'b0;
                run_pend_next = run;
                f3_pend_next  = f3;
            end
            else if (run)
            begin
                state_next   = rlbc_pkg::ST_RUN_HDR;
                f3_pend_next = f3;
            end
            else if (f3)
            begin
                state_next = rlbc_pkg::ST_LIT_HDR;
                grp_n_next = f3_n_next;
                in_f3_next = 1'b1;
            end
        end
        else if (advance)
        begin
            unique case (state_reg)
                rlbc_pkg::ST_LIT_HDR:
                begin
                    if (grp_n_reg != '0)
                    begin
                        rd_en      = 1'b1;
                        rd_addr    = '0;
                        idx_next   = '0;
                        state_next = rlbc_pkg::ST_LIT_DATA;
                    end
                    else if (in_f3_reg)
                    begin
                        state_next = rlbc_pkg::ST_LIT_TAIL;
                    end
                    else
                    begin
                        chain = 1'b1;
                    end
                end
                rlbc_pkg::ST_LIT_DATA:
                begin
                    if (idx_inc < grp_n_reg)
                    begin
                        rd_en    = 1'b1;
                        idx_next = idx_inc;
                    end
                    else if (in_f3_reg)
                    begin
                        state_next = rlbc_pkg::ST_LIT_TAIL;
                    end
                    else
                    begin
                        chain = 1'b1;
                    end
                end
                rlbc_pkg::ST_LIT_TAIL:
                begin
                    state_next = rlbc_pkg::ST_IDLE;
                end
                rlbc_pkg::ST_RUN_HDR:
                begin
                    state_next = rlbc_pkg::ST_RUN_BYTE;
                end
                rlbc_pkg::ST_RUN_BYTE:
                begin
                    chain = 1'b1;
                end
                default:
                begin
                    state_next = rlbc_pkg::ST_IDLE;
                end
            endcase

            // next piece of the same request
            if (chain)
            begin
                if (run_pend_reg)
                begin
                    state_next    = rlbc_pkg::ST_RUN_HDR;
                    run_pend_next = 1'b0;
                end
                else if (f3_pend_reg)
                begin
                    state_next   = rlbc_pkg::ST_LIT_HDR;
                    grp_n_next   = f3_n_reg;
                    in_f3_next   = 1'b1;
                    f3_pend_next = 1'b0;
                end
                else
                begin
                    state_next = rlbc_pkg::ST_IDLE;
                end
            end
        end
    end

    // Output register: loads whenever a coded byte moves forward
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (out_free)
        begin
            out_valid_next = advance;
            out_byte_next  = emit_byte;
            out_last_next  = emit_last;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= rlbc_pkg::PH_EMPTY;
            held_reg      <= 8'd0;
            rlen_reg      <= 8'd0;
            count_reg     <= '0;
            state_reg     <= rlbc_pkg::ST_IDLE;
            run_pend_reg  <= 1'b0;
            f3_pend_reg   <= 1'b0;
            in_f3_reg     <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            rlen_reg      <= rlen_next;
            count_reg     <= count_next;
            state_reg     <= state_next;
            run_pend_reg  <= run_pend_next;
            f3_pend_reg   <= f3_pend_next;
            in_f3_reg     <= in_f3_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_len_reg  <= run_len_next;
        run_byte_reg <= run_byte_next;
        f3_n_reg     <= f3_n_next;
        tail_reg     <= tail_next;
        grp_n_reg    <= grp_n_next;
        idx_reg      <= idx_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    // Literal store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            lit_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_rdata_reg <= lit_mem[rd_addr];
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RLBC_ASSERT_NOW(a_count_below_max, 1'b1, count_reg < rlbc_pkg::MAX_CNT)
    `RLBC_ASSERT_NOW(a_run_no_literals, phase_reg == rlbc_pkg::PH_RUN, count_reg == '0)
    `RLBC_ASSERT_NOW(a_run_len_range, phase_reg == rlbc_pkg::PH_RUN,
        (rlen_reg >= rlbc_pkg::RUN_START) && (rlen_reg <= rlbc_pkg::RUN_MAX))
    `RLBC_ASSERT_NOW(a_read_in_group, state_reg == rlbc_pkg::ST_LIT_DATA, idx_reg < grp_n_reg)
    `RLBC_ASSERT_NEXT(a_last_ends_stream, advance && emit_last,
        (state_reg == rlbc_pkg::ST_IDLE) && (phase_reg == rlbc_pkg::PH_EMPTY))

endmodule
